FILE: hw/rtl/wsot_pkg.sv
// ----------------------------------------------------------------------------
// wsot_pkg
// Shared types and constants for the weekly outlet schedule timer.
// ----------------------------------------------------------------------------
package wsot_pkg;

    localparam int ENTRY_COUNT = 6;
    localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

    localparam int COUNT_W     = 16;
    localparam int S_TDATA_W   = 64;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 40;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_SLEEP = 2'd2,
        CMD_WAKE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_ON   = 2'd1,
        ACT_OFF  = 2'd2
    } act_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [6:0] mask;
        logic [4:0] on_h;
        logic [5:0] on_m;
        logic [4:0] off_h;
        logic [5:0] off_m;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: hw/rtl/weekly_schedule_outlet_timer_unit.sv
// ----------------------------------------------------------------------------
// weekly_schedule_outlet_timer_unit
// Weekly on/off schedule table with sleep and wake minute countdowns.
// ----------------------------------------------------------------------------
// One result word per input word. The schedule entries live in a RAM with a
// registered read; a minute tick walks the entries through its single read
// port, one entry per cycle. Entries written since reset carry a valid flag;
// an unwritten entry never matches. A finished result sits in the output
// register while the next word is taken in.
module weekly_schedule_outlet_timer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // command[1:0]
    input  logic [wsot_pkg::S_TUSER_W-1:0] s_tuser,
    // weekday[2:0] now_hour[7:3] now_minute[13:8] entry_index[16:14]
    // day_mask[23:17] on_hour[28:24] on_minute[34:29] off_hour[39:35]
    // off_minute[45:40] count_value[61:46], zero fill above
    input  logic [wsot_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // outlet_action[1:0] sleep_left[17:2] wake_left[33:18], zero fill above
    output logic [wsot_pkg::M_TDATA_W-1:0] m_tdata
);

    import wsot_pkg::*;

    // input unpack
    logic [2:0]         in_weekday;
    logic [4:0]         in_hour;
    logic [5:0]         in_minute;
    logic [2:0]         in_index;
    entry_t             in_entry;
    logic [COUNT_W-1:0] in_count;

    assign in_weekday     = s_tdata[2:0];
    assign in_hour        = s_tdata[7:3];
    assign in_minute      = s_tdata[13:8];
    assign in_index       = s_tdata[16:14];
    assign in_entry.mask  = s_tdata[23:17];
    assign in_entry.on_h  = s_tdata[28:24];
    assign in_entry.on_m  = s_tdata[34:29];
    assign in_entry.off_h = s_tdata[39:35];
    assign in_entry.off_m = s_tdata[45:40];
    assign in_count       = s_tdata[61:46];

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [2:0]         day_reg, day_next;
    logic [4:0]         hour_reg, hour_next;
    logic [5:0]         minute_reg, minute_next;
    logic [COUNT_W-1:0] load_reg, load_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    act_t               act_reg, act_next;
    logic [COUNT_W-1:0] sleep_reg, sleep_next;
    logic [COUNT_W-1:0] wake_reg, wake_next;
    logic [ENTRY_COUNT-1:0] valid_reg, valid_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;
    logic [4:0]         index_ext;
    logic [7:0]         mask_ext;
    logic               out_free;

    assign rd_entry  = entry_t'(ram_rdata);
    assign index_ext = {2'b00, in_index};
    assign mask_ext  = {1'b0, rd_entry.mask};
    assign out_free  = !m_tvalid_reg || m_tready;

    wsot_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRY_COUNT),
        .ADDR_W(IDX_W)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(in_entry),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            sleep_reg    <= '0;
            wake_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
            act_reg      <= ACT_NONE;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            sleep_reg    <= sleep_next;
            wake_reg     <= wake_next;
            m_tvalid_reg <= m_tvalid_next;
            idx_reg      <= idx_next;
            act_reg      <= act_next;
        end
        cmd_reg     <= cmd_next;
        day_reg     <= day_next;
        hour_reg    <= hour_next;
        minute_reg  <= minute_next;
        load_reg    <= load_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        act_t      act_v;
        logic [COUNT_W-1:0] sleep_v;
        logic [COUNT_W-1:0] wake_v;

        state_next    = state_reg;
        cmd_next      = cmd_reg;
        day_next      = day_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        load_next     = load_reg;
        idx_next      = idx_reg;
        act_next      = act_reg;
        sleep_next    = sleep_reg;
        wake_next     = wake_reg;
        valid_next    = valid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = index_ext[IDX_W-1:0];
        ram_re        = 1'b0;
        ram_raddr     = '0;
        act_v         = act_reg;
        sleep_v       = sleep_reg;
        wake_v        = wake_reg;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd_next    = cmd_t'(s_tuser[1:0]);
                    day_next    = in_weekday;
                    hour_next   = in_hour;
                    minute_next = in_minute;
                    load_next   = in_count;
                    idx_next    = '0;
                    act_next    = ACT_NONE;
                    if (cmd_t'(s_tuser[1:0]) == CMD_TICK) begin
                        ram_re     = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        if (cmd_t'(s_tuser[1:0]) == CMD_WRITE &&
                            index_ext < 5'(ENTRY_COUNT)) begin
                            ram_we = 1'b1;
                            valid_next[index_ext[IDX_W-1:0]] = 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                // data of entry idx_reg is on the read port now
                if (valid_reg[idx_reg] && day_reg != 3'd7 && mask_ext[day_reg]) begin
                    if (hour_reg == rd_entry.on_h && minute_reg == rd_entry.on_m) begin
                        act_v = ACT_ON;
                    end
                    if (hour_reg == rd_entry.off_h && minute_reg == rd_entry.off_m) begin
                        act_v = ACT_OFF;
                    end
                end
                act_next = act_v;
                if (idx_reg == IDX_W'(ENTRY_COUNT - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    case (cmd_reg)
                        CMD_TICK: begin
                            if (sleep_reg != '0) begin
                                sleep_v = sleep_reg - 1'b1;
                                if (sleep_v == '0) begin
                                    act_v = ACT_OFF;
                                end
                            end
                            if (wake_reg != '0) begin
                                wake_v = wake_reg - 1'b1;
                                if (wake_v == '0) begin
                                    act_v = ACT_ON;
                                end
                            end
                        end
                        CMD_SLEEP: begin
                            sleep_v = load_reg;
                            act_v   = ACT_NONE;
                        end
                        CMD_WAKE: begin
                            wake_v = load_reg;
                            act_v  = ACT_NONE;
                        end
                        default: begin
                            act_v = ACT_NONE;
                        end
                    endcase
                    sleep_next    = sleep_v;
                    wake_next     = wake_v;
                    m_tdata_next  = {6'd0, wake_v, sleep_v, act_v};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: hw/rtl/wsot_ram.sv
// ----------------------------------------------------------------------------
// wsot_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wsot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: tb/sv/tb_weekly_schedule_outlet_timer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weekly_schedule_outlet_timer_unit
// Self-checking bench for the weekly outlet schedule timer. Directed words
// cover the empty table, entry matching and priority, ignored writes,
// out-of-range times and both countdowns. A long random run follows, where
// most ticks are aimed at times stored in the table. An in-bench predictor
// computes the expected result word for every accepted input word. Sender
// bursts and receiver stalls vary throughout the run.
// ----------------------------------------------------------------------------
module tb_weekly_schedule_outlet_timer_unit;

    import wsot_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_WORDS = 1800;

    typedef struct {
        cmd_t        cmd;
        logic [2:0]  weekday;
        logic [4:0]  now_h;
        logic [5:0]  now_m;
        logic [2:0]  idx;
        entry_t      ent;
        logic [15:0] count;
    } sched_word_t;

    typedef struct {
        act_t        act;
        logic [15:0] sleep_left;
        logic [15:0] wake_left;
    } outlet_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    // predictor state
    entry_t      plan_table [ENTRY_COUNT];
    logic [15:0] sleep_cnt;
    logic [15:0] wake_cnt;

    outlet_result_t pending_outlet_q [$];

    int          mismatch_count = 0;
    int          result_count   = 0;
    int          idle_cycles    = 0;
    int          burst_left     = 0;
    bit          sender_gaps    = 1'b1;
    logic [9:0]  rx_phase       = '0;

    weekly_schedule_outlet_timer_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic outlet_result_t advance_schedule(input sched_word_t w);
        outlet_result_t r;
        r.act = ACT_NONE;
        case (w.cmd)
            CMD_TICK: begin
                if (w.weekday != 3'd7) begin
                    for (int k = 0; k < ENTRY_COUNT; k++) begin
                        if (plan_table[k].mask[w.weekday]) begin
                            if (w.now_h == plan_table[k].on_h && w.now_m == plan_table[k].on_m)
                                r.act = ACT_ON;
                            if (w.now_h == plan_table[k].off_h && w.now_m == plan_table[k].off_m)
                                r.act = ACT_OFF;
                        end
                    end
                end
                // countdowns are applied after the table, wake last
                if (sleep_cnt != 16'd0) begin
                    sleep_cnt = sleep_cnt - 16'd1;
                    if (sleep_cnt == 16'd0)
                        r.act = ACT_OFF;
                end
                if (wake_cnt != 16'd0) begin
                    wake_cnt = wake_cnt - 16'd1;
                    if (wake_cnt == 16'd0)
                        r.act = ACT_ON;
                end
            end
            CMD_WRITE: begin
                if (w.idx < ENTRY_COUNT)
                    plan_table[w.idx] = w.ent;
            end
            CMD_SLEEP: sleep_cnt = w.count;
            default:   wake_cnt  = w.count;
        endcase
        r.sleep_left = sleep_cnt;
        r.wake_left  = wake_cnt;
        return r;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_word(input sched_word_t w);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[61:0] = {w.count, w.ent.off_m, w.ent.off_h, w.ent.on_m, w.ent.on_h,
                   w.ent.mask, w.idx, w.now_m, w.now_h, w.weekday};
        return d;
    endfunction

    // every field random over its full width; unused fields stay as noise
    function automatic sched_word_t random_fill();
        sched_word_t w;
        w.cmd       = cmd_t'($urandom_range(0, 3));
        w.weekday   = 3'($urandom_range(0, 7));
        w.now_h     = 5'($urandom_range(0, 31));
        w.now_m     = 6'($urandom_range(0, 63));
        w.idx       = 3'($urandom_range(0, 7));
        w.ent.mask  = 7'($urandom_range(0, 127));
        w.ent.on_h  = 5'($urandom_range(0, 31));
        w.ent.on_m  = 6'($urandom_range(0, 63));
        w.ent.off_h = 5'($urandom_range(0, 31));
        w.ent.off_m = 6'($urandom_range(0, 63));
        w.count     = 16'($urandom_range(0, 65535));
        return w;
    endfunction

    function automatic sched_word_t tick_word(input int d, input int h, input int m);
        sched_word_t w;
        w         = random_fill();
        w.cmd     = CMD_TICK;
        w.weekday = 3'(d);
        w.now_h   = 5'(h);
        w.now_m   = 6'(m);
        return w;
    endfunction

    function automatic sched_word_t write_word(input int idx, input int mask,
                                               input int on_h, input int on_m,
                                               input int off_h, input int off_m);
        sched_word_t w;
        w           = random_fill();
        w.cmd       = CMD_WRITE;
        w.idx       = 3'(idx);
        w.ent.mask  = 7'(mask);
        w.ent.on_h  = 5'(on_h);
        w.ent.on_m  = 6'(on_m);
        w.ent.off_h = 5'(off_h);
        w.ent.off_m = 6'(off_m);
        return w;
    endfunction

    function automatic sched_word_t load_word(input cmd_t cmd, input int count);
        sched_word_t w;
        w       = random_fill();
        w.cmd   = cmd;
        w.count = 16'(count);
        return w;
    endfunction

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    task automatic send_word(input sched_word_t w);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            if (sender_gaps) begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    s_tvalid = 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid = 1'b1;
        s_tuser  = w.cmd;
        s_tdata  = pack_word(w);
        do @(posedge aclk); while (!s_tready);
        pending_outlet_q.push_back(advance_schedule(w));
        burst_left--;
    endtask

    task automatic sender_idle();
        @(negedge aclk);
        s_tvalid   = 1'b0;
        burst_left = 0;
    endtask

    task automatic pause_until_drained();
        sender_idle();
        while (pending_outlet_q.size() != 0) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        rx_phase <= rx_phase + 10'd1;
        case (rx_phase[9:7])
            3'd0, 3'd1: m_tready <= 1'b1;
            3'd2:       m_tready <= rx_phase[0];
            3'd3:       m_tready <= (rx_phase[1:0] == 2'd0);
            3'd6:       m_tready <= (rx_phase[4:0] == 5'd0);   // long stalls
            3'd7:       m_tready <= ($urandom_range(0, 3) != 0);
            default:    m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at result word %0d: %s", result_count, what);
    endtask

    task automatic check_result();
        outlet_result_t exp;
        if (pending_outlet_q.size() == 0) begin
            report_mismatch("result word with nothing pending");
        end else begin
            exp = pending_outlet_q.pop_front();
            if (m_tdata[1:0] !== exp.act)
                report_mismatch($sformatf("outlet_action got %0d want %0d",
                                          m_tdata[1:0], exp.act));
            if (m_tdata[17:2] !== exp.sleep_left)
                report_mismatch($sformatf("sleep_left got %0d want %0d",
                                          m_tdata[17:2], exp.sleep_left));
            if (m_tdata[33:18] !== exp.wake_left)
                report_mismatch($sformatf("wake_left got %0d want %0d",
                                          m_tdata[33:18], exp.wake_left));
        end
        result_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_result();
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_empty_table();
        // zero masks never apply, zero counts stay put
        send_word(tick_word(0, 0, 0));
        send_word(tick_word(6, 23, 59));
        send_word(tick_word(7, 31, 63));
    endtask

    task automatic test_schedule_entries();
        send_word(write_word(0, 7'h7F, 0, 0, 23, 59));
        send_word(write_word(5, 7'h01, 31, 63, 24, 60));   // out-of-range times
        send_word(write_word(6, 7'h7F, 12, 34, 12, 35));   // ignored
        send_word(write_word(7, 7'h7F, 12, 34, 12, 35));   // ignored
        send_word(tick_word(3, 0, 0));
        send_word(tick_word(6, 23, 59));
        send_word(tick_word(0, 31, 63));
        send_word(tick_word(1, 31, 63));
        send_word(tick_word(0, 24, 60));
        send_word(tick_word(7, 0, 0));                       // no entry on day 7
        send_word(tick_word(0, 12, 34));
        // on and off at the same time: off wins within one entry
        send_word(write_word(1, 7'h7F, 5, 5, 5, 5));
        send_word(tick_word(2, 5, 5));
        // later entry wins over earlier one
        send_word(write_word(2, 7'h40, 1, 1, 7, 7));
        send_word(write_word(3, 7'h40, 7, 7, 2, 2));
        send_word(tick_word(6, 7, 7));
    endtask

    task automatic test_countdowns();
        send_word(load_word(CMD_SLEEP, 1));
        send_word(tick_word(7, 0, 0));
        send_word(load_word(CMD_WAKE, 1));
        send_word(tick_word(7, 0, 0));
        // both expire on one tick: wake comes last
        send_word(load_word(CMD_SLEEP, 2));
        send_word(load_word(CMD_WAKE, 2));
        send_word(tick_word(7, 0, 0));
        send_word(tick_word(7, 0, 0));
        // sleep expiry overrides an entry's on
        send_word(write_word(4, 7'h7F, 10, 10, 3, 0));
        send_word(load_word(CMD_SLEEP, 1));
        send_word(tick_word(4, 10, 10));
        send_word(load_word(CMD_SLEEP, 16'hFFFF));
        send_word(load_word(CMD_WAKE, 16'hFFFF));
        send_word(tick_word(5, 0, 0));
        send_word(load_word(CMD_SLEEP, 0));
        send_word(load_word(CMD_WAKE, 0));
        send_word(tick_word(5, 0, 0));
    endtask

    function automatic int pick_count();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(0, 65535);
            2:       return 16'hFFFF;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic sched_word_t random_word();
        sched_word_t w;
        int sel;
        int k;
        int d;
        sel = $urandom_range(0, 99);
        w   = random_fill();
        if (sel < 15) begin
            w.cmd = CMD_WRITE;
            w.idx = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, ENTRY_COUNT - 1));
            if ($urandom_range(0, 9) != 0) begin
                w.ent.on_h  = 5'($urandom_range(0, 23));
                w.ent.on_m  = 6'($urandom_range(0, 59));
                w.ent.off_h = 5'($urandom_range(0, 23));
                w.ent.off_m = 6'($urandom_range(0, 59));
            end
        end else if (sel < 23) begin
            w = load_word(CMD_SLEEP, pick_count());
        end else if (sel < 31) begin
            w = load_word(CMD_WAKE, pick_count());
        end else begin
            w.cmd = CMD_TICK;
            // aim most ticks at a stored on or off time on an active day
            if ($urandom_range(0, 99) < 60) begin
                k = $urandom_range(0, ENTRY_COUNT - 1);
                if (plan_table[k].mask != 7'd0) begin
                    do d = $urandom_range(0, 6); while (!plan_table[k].mask[d]);
                    w.weekday = 3'(d);
                end
                if ($urandom_range(0, 1) == 0) begin
                    w.now_h = plan_table[k].on_h;
                    w.now_m = plan_table[k].on_m;
                end else begin
                    w.now_h = plan_table[k].off_h;
                    w.now_m = plan_table[k].off_m;
                end
            end
        end
        return w;
    endfunction

    task automatic test_random_traffic();
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // alternate stretches with and without sender gaps
            if (n % 300 == 0)
                sender_gaps = ((n / 300) % 2) == 1;
            send_word(random_word());
            if (n % 400 == 399)
                pause_until_drained();
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = CMD_TICK;
        s_tdata  = '0;
        for (int k = 0; k < ENTRY_COUNT; k++)
            plan_table[k] = '0;
        sleep_cnt = '0;
        wake_cnt  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_table();
        test_schedule_entries();
        test_countdowns();
        pause_until_drained();
        test_random_traffic();

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
